/* hw/rtl/eda_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eda_pkg
// shared types and constants of the exponential decaying average block
// ----------------------------------------------------------------------------
package eda_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int COEF_W             = 16;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd4096;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_ADD  = 2'd1,
        OP_TICK = 2'd2,
        OP_IDLE = 2'd3
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SMOOTHING_COEFFICIENT = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/exp_decaying_average.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exp_decaying_average
// exponential moving average and rate of a signed fixed-point input
// ----------------------------------------------------------------------------
// Each beat sets the input accumulator (operation 0), adds to it with
// saturation (1), ticks both smoothers (2) or does nothing (3), and returns
// one beat carrying the average and rate after that item. The block takes one
// item per cycle while the output is not stalled, through an input register,
// then the accumulator update and both multiply-add smoothers in one pass into
// the result register; that multiply-add path sets the clock.
// The coefficient lives at byte address 0 of the apb port.
// ----------------------------------------------------------------------------
module exp_decaying_average #(
    parameter int DATA_WIDTH = eda_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [eda_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [eda_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [eda_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [1:0]                     operation,
    input  wire logic signed [DATA_WIDTH-1:0]   value,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic signed [DATA_WIDTH-1:0]   average,
    output      logic signed [DATA_WIDTH-1:0]   rate
);

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    eda_pkg::op_t                   s1_op_reg;
    logic signed [DATA_WIDTH-1:0]   s1_value_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [DATA_WIDTH-1:0]   average_reg;
    logic signed [DATA_WIDTH-1:0]   rate_reg;
    logic signed [DATA_WIDTH-1:0]   average_calc;
    logic signed [DATA_WIDTH-1:0]   rate_calc;
    logic [eda_pkg::COEF_W-1:0]     coef;
    logic                           out_free;
    logic                           in_fire;
    eda_pkg::ctrl_t                 core_ctrl;

    eda_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign core_ctrl.valid = s1_valid_reg && out_free;
    assign core_ctrl.op    = s1_op_reg;

    eda_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (core_ctrl),
        .value   (s1_value_reg),
        .coef    (coef),
        .average (average_calc),
        .rate    (rate_calc)
    );

    assign s1_valid_next  = in_fire || (s1_valid_reg && !out_free);
    assign out_valid_next = out_free ? s1_valid_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= eda_pkg::op_t'(operation);
            s1_value_reg <= value;
        end
        if (core_ctrl.valid)
        begin
            average_reg <= average_calc;
            rate_reg    <= rate_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign rate      = rate_reg;

endmodule
`default_nettype wire

/* hw/rtl/eda_smoother.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eda_smoother
// first-order smoothing step: old + floor(coef * sat(target - old) / 2^16)
// ----------------------------------------------------------------------------
module eda_smoother #(
    parameter int DATA_WIDTH = eda_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic signed [DATA_WIDTH-1:0]      old_value,
    input  wire logic signed [DATA_WIDTH-1:0]      target,
    input  wire logic        [eda_pkg::COEF_W-1:0] coef,
    output      logic signed [DATA_WIDTH-1:0]      result
);

    localparam int PROD_W = DATA_WIDTH + eda_pkg::COEF_W + 1;

    logic signed [DATA_WIDTH:0]        delta_wide;
    logic signed [DATA_WIDTH-1:0]      delta;
    logic signed [eda_pkg::COEF_W:0]   coef_s;
    logic signed [PROD_W-1:0]          prod;
    logic signed [DATA_WIDTH-1:0]      scaled;

    assign delta_wide = {target[DATA_WIDTH-1], target}
                      - {old_value[DATA_WIDTH-1], old_value};

    always_comb
    begin
        if (delta_wide[DATA_WIDTH] != delta_wide[DATA_WIDTH-1])
        begin
            delta = delta_wide[DATA_WIDTH]
                  ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                  : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            delta = delta_wide[DATA_WIDTH-1:0];
        end
    end

    assign coef_s = $signed({1'b0, coef});
    assign prod   = PROD_W'(delta) * PROD_W'(coef_s);
    // floor division by 2^16 is an arithmetic shift
    assign scaled = prod[eda_pkg::COEF_W +: DATA_WIDTH];
    assign result = old_value + scaled;

endmodule
`default_nettype wire

/* hw/rtl/eda_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eda_core
// input accumulator, previous level and both smoothers, one item per cycle
// ----------------------------------------------------------------------------
module eda_core #(
    parameter int DATA_WIDTH = eda_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire eda_pkg::ctrl_t                    ctrl,
    input  wire logic signed [DATA_WIDTH-1:0]      value,
    input  wire logic        [eda_pkg::COEF_W-1:0] coef,
    output      logic signed [DATA_WIDTH-1:0]      average,
    output      logic signed [DATA_WIDTH-1:0]      rate
);

    logic signed [DATA_WIDTH-1:0] level_reg;
    logic signed [DATA_WIDTH-1:0] level_next;
    logic signed [DATA_WIDTH-1:0] prev_reg;
    logic signed [DATA_WIDTH-1:0] prev_next;
    logic signed [DATA_WIDTH-1:0] avg_reg;
    logic signed [DATA_WIDTH-1:0] avg_next;
    logic signed [DATA_WIDTH-1:0] rate_reg;
    logic signed [DATA_WIDTH-1:0] rate_next;
    logic                         clear_on_tick_reg;
    logic                         clear_on_tick_next;

    logic signed [DATA_WIDTH:0]   sum_wide;
    logic signed [DATA_WIDTH-1:0] sum_sat;
    logic signed [DATA_WIDTH:0]   diff_wide;
    logic signed [DATA_WIDTH-1:0] diff_sat;
    logic signed [DATA_WIDTH-1:0] avg_new;
    logic signed [DATA_WIDTH-1:0] rate_new;

    assign sum_wide  = {level_reg[DATA_WIDTH-1], level_reg} + {value[DATA_WIDTH-1], value};
    assign diff_wide = {level_reg[DATA_WIDTH-1], level_reg} - {prev_reg[DATA_WIDTH-1], prev_reg};

    always_comb
    begin
        if (sum_wide[DATA_WIDTH] != sum_wide[DATA_WIDTH-1])
        begin
            sum_sat = sum_wide[DATA_WIDTH]
                    ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                    : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (diff_wide[DATA_WIDTH] != diff_wide[DATA_WIDTH-1])
        begin
            diff_sat = diff_wide[DATA_WIDTH]
                     ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                     : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            diff_sat = diff_wide[DATA_WIDTH-1:0];
        end
    end

    eda_smoother #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rate_smoother (
        .old_value (rate_reg),
        .target    (diff_sat),
        .coef      (coef),
        .result    (rate_new)
    );

    eda_smoother #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_avg_smoother (
        .old_value (avg_reg),
        .target    (level_reg),
        .coef      (coef),
        .result    (avg_new)
    );

    always_comb
    begin
        level_next         = level_reg;
        prev_next          = prev_reg;
        avg_next           = avg_reg;
        rate_next          = rate_reg;
        clear_on_tick_next = clear_on_tick_reg;
        if (ctrl.valid)
        begin
            unique case (ctrl.op)
                eda_pkg::OP_SET:
                begin
                    level_next         = value;
                    clear_on_tick_next = 1'b0;
                end
                eda_pkg::OP_ADD:
                begin
                    level_next         = sum_sat;
                    clear_on_tick_next = 1'b1;
                end
                eda_pkg::OP_TICK:
                begin
                    prev_next = level_reg;
                    avg_next  = avg_new;
                    rate_next = rate_new;
                    if (clear_on_tick_reg)
                    begin
                        level_next = '0;
                    end
                end
                eda_pkg::OP_IDLE:
                begin
                    level_next = level_reg;
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg         <= '0;
            prev_reg          <= '0;
            avg_reg           <= '0;
            rate_reg          <= '0;
            clear_on_tick_reg <= 1'b1;
        end
        else
        begin
            level_reg         <= level_next;
            prev_reg          <= prev_next;
            avg_reg           <= avg_next;
            rate_reg          <= rate_next;
            clear_on_tick_reg <= clear_on_tick_next;
        end
    end

    assign average = avg_next;
    assign rate    = rate_next;

`ifndef NO_ASSERTIONS
    a_set_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid && ctrl.op == eda_pkg::OP_SET |=> !clear_on_tick_reg)
        else $error("set beat did not clear the clear-on-tick flag");

    a_add_arms_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid && ctrl.op == eda_pkg::OP_ADD |=> clear_on_tick_reg)
        else $error("increment beat did not arm the clear-on-tick flag");

    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid && ctrl.op == eda_pkg::OP_TICK && clear_on_tick_reg
        |=> level_reg == '0)
        else $error("tick after increment left the accumulator set");

    a_smoothers_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.valid && ctrl.op == eda_pkg::OP_TICK)
        |=> $stable(avg_reg) && $stable(rate_reg) && $stable(prev_reg))
        else $error("smoother state moved without a tick");
`endif

endmodule
`default_nettype wire

/* hw/rtl/eda_apb_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eda_apb_regs
// apb register file holding the smoothing coefficient
// ----------------------------------------------------------------------------
module eda_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [eda_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [eda_pkg::APB_DATA_W-1:0]   pwdata,
    output      logic [eda_pkg::APB_DATA_W-1:0]   prdata,
    output      logic                             pready,
    output      logic [eda_pkg::COEF_W-1:0]       coef
);

    logic [eda_pkg::COEF_W-1:0]    coef_reg;
    logic [eda_pkg::COEF_W-1:0]    coef_next;
    logic [eda_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[eda_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        coef_next = coef_reg;
        prdata    = '0;
        unique case (reg_idx)
            eda_pkg::REG_SMOOTHING_COEFFICIENT:
            begin
                prdata = {{(eda_pkg::APB_DATA_W-eda_pkg::COEF_W){1'b0}}, coef_reg};
                if (wr_en)
                begin
                    coef_next = pwdata[eda_pkg::COEF_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= eda_pkg::COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

/* verif/tb_exp_decaying_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exp_decaying_average
// self-checking bench for the exponential average and rate block
// ----------------------------------------------------------------------------
// Beats of set, add, tick and idle operations go in through a queue-fed
// driver. A local model of the accumulator and both smoothers predicts the
// average and rate of every beat, and a monitor compares each result beat
// with the oldest prediction. The coefficient is rewritten over the apb port
// between phases, each phase draining first, so it sweeps its extremes and
// random settings. Both sides insert random gaps, except in one quiet phase.
// ----------------------------------------------------------------------------
module tb_exp_decaying_average;

    import eda_pkg::*;

    localparam int     DW         = DATA_WIDTH_DEFAULT;
    localparam longint DATA_MAX   = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint DATA_MIN   = -DATA_MAX - 1;
    localparam int     PHASE_LEN  = 270;
    localparam int     STUCK_MAX  = 5000;
    localparam int     PRINT_MAX  = 40;

    typedef struct packed {
        op_t                   op;
        logic signed [DW-1:0]  value;
    } sample_t;

    typedef struct packed {
        logic signed [DW-1:0]  average;
        logic signed [DW-1:0]  rate;
    } reading_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    sample_t                    in_sample = '{op: OP_IDLE, value: '0};
    logic [1:0]                 operation;
    logic signed [DW-1:0]       value;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DW-1:0]       average;
    logic signed [DW-1:0]       rate;

    sample_t                    pending_samples[$];
    reading_t                   expected_readings[$];
    reading_t                   oldest_reading;
    int                         error_count = 0;
    int                         stuck_cycles = 0;
    logic                       no_gaps = 1'b0;

    // local copy of the block's state
    logic [COEF_W-1:0]          coef_q = COEF_RESET;
    longint                     level_q = 0;
    longint                     last_tick_level = 0;
    longint                     avg_q = 0;
    longint                     rate_q = 0;
    logic                       counter_mode = 1'b1;

    assign operation = in_sample.op;
    assign value     = in_sample.value;

    exp_decaying_average #(
        .DATA_WIDTH (DW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .average   (average),
        .rate      (rate)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint saturate(input longint x);
        if (x > DATA_MAX)
            return DATA_MAX;
        if (x < DATA_MIN)
            return DATA_MIN;
        return x;
    endfunction

    // one smoother step, product floored by the coefficient's fraction bits
    function automatic longint smooth_toward(input longint held, input longint goal);
        return held + ((saturate(goal - held) * longint'(coef_q)) >>> COEF_W);
    endfunction

    task automatic predict_reading(input sample_t s);
        longint v;
        longint delta;
        v = $signed(s.value);
        case (s.op)
            OP_SET:
            begin
                level_q      = v;
                counter_mode = 1'b0;
            end
            OP_ADD:
            begin
                level_q      = saturate(level_q + v);
                counter_mode = 1'b1;
            end
            OP_TICK:
            begin
                delta           = saturate(level_q - last_tick_level);
                last_tick_level = level_q;
                rate_q          = smooth_toward(rate_q, delta);
                avg_q           = smooth_toward(avg_q, level_q);
                if (counter_mode)
                    level_q = 0;
            end
            default: ;
        endcase
        expected_readings.push_back('{average: DW'(avg_q), rate: DW'(rate_q)});
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DW - 1){1'b1}}};
            1:       return {1'b1, {(DW - 1){1'b0}}};
            2, 3, 4: return DW'($signed(r[19:0]));
            5:       return DW'($signed(r[7:0]));
            default: return DW'(r);
        endcase
    endfunction

    task automatic queue_random_phase(input int count);
        int   pick;
        op_t  op;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                op = OP_SET;
            else if (pick < 55)
                op = OP_ADD;
            else if (pick < 90)
                op = OP_TICK;
            else
                op = OP_IDLE;
            pending_samples.push_back('{op: op, value: pick_value()});
        end
    endtask

    task automatic queue_sample(input op_t op, input logic [DW-1:0] v);
        pending_samples.push_back('{op: op, value: v});
    endtask

    // sender holds off until every result beat is back
    task automatic drain();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_coefficient(input logic [COEF_W-1:0] c);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_SMOOTHING_COEFFICIENT));
        pwdata  <= APB_DATA_W'(c);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coef_q = c;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_sample <= '{op: OP_IDLE, value: '0};
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_reading(in_sample);
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 11))
                begin
                    in_valid  <= 1'b1;
                    in_sample <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("result beat avg %0d rate %0d with none pending",
                                              average, rate));
                else
                begin
                    oldest_reading = expected_readings.pop_front();
                    if (average !== oldest_reading.average)
                        report_mismatch($sformatf("average %0d, want %0d",
                                                  average, oldest_reading.average));
                    if (rate !== oldest_reading.rate)
                        report_mismatch($sformatf("rate %0d, want %0d",
                                                  rate, oldest_reading.rate));
                end
            end
            out_stall <= !no_gaps && ($urandom_range(0, 99) < 11);
        end
    end

    // watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_MAX)
        begin
            $display("[%0t] timeout, no beat for %0d cycles", $realtime, stuck_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [COEF_W-1:0] coef_plan[7];
        coef_plan = '{16'd65535, 16'd0, 16'd1, COEF_W'($urandom_range(0, 65535)),
                      16'd32768, COEF_W'($urandom_range(0, 65535)), 16'd4096};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats under the reset coefficient
        queue_sample(OP_TICK, '0);
        queue_sample(OP_SET,  32'h7FFF_FFFF);
        queue_sample(OP_TICK, 32'hFFFF_FFFF);
        queue_sample(OP_SET,  32'h8000_0000);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_ADD,  32'h8000_0000);
        queue_sample(OP_ADD,  32'h8000_0000);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_SET,  32'h7FFF_FFFF);
        queue_sample(OP_ADD,  32'h7FFF_FFFF);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_IDLE, 32'h5A5A_5A5A);
        queue_sample(OP_ADD,  32'hFFFF_FFFF);
        queue_sample(OP_ADD,  32'h0000_0001);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_SET,  32'hFFFF_0000);
        queue_sample(OP_TICK, 32'hA5A5_A5A5);
        queue_sample(OP_IDLE, 32'hFFFF_FFFF);
        queue_sample(OP_SET,  32'h0001_0000);
        queue_sample(OP_TICK, '0);
        queue_sample(OP_TICK, '0);
        drain();

        foreach (coef_plan[i])
        begin
            no_gaps = (i == 4);
            write_coefficient(coef_plan[i]);
            @(negedge clk);
            queue_random_phase(PHASE_LEN);
            drain();
        end
        no_gaps = 1'b0;

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
